@@ hw/rtl/erpi_pkg.sv @@
// Shared types and constants for the echo range proximity indicator.
package erpi_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 9;
  localparam int TIMEOUT_W  = 16;
  localparam int CM_W       = 10;
  localparam int DIGIT_W    = 4;
  localparam int DUTY_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NEAR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [THR_W-1:0]     NEAR_RESET    = 9'd10;
  localparam logic [THR_W-1:0]     FAR_RESET     = 9'd100;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd46400;

  // duty divider: 17-bit dividend, 9-bit divisor
  localparam int DVSR_W = 9;
  localparam int RAMP_W = DVSR_W + 8;
  localparam int DIV_W  = RAMP_W;

  // dvd/58 and tenths/10 by reciprocal multiply, exact over the clamped tenths range
  localparam int TDVD_W       = 19;
  localparam int TENTHS_W     = 13;
  localparam int TENTHS_SHIFT = 24;
  localparam int CM_SHIFT     = 16;
  localparam logic [TDVD_W-1:0]   TENTHS_RECIP = 19'd289263;
  localparam logic [TENTHS_W-1:0] CM_RECIP     = 13'd6554;

  localparam int unsigned TENTHS_DIVISOR = 58;
  localparam int unsigned CM_DIVISOR     = 10;
  localparam int unsigned MAX_TENTHS     = 5659;
  localparam int unsigned SPACING_CM     = 5;

  localparam logic [DUTY_W-1:0]  DUTY_MAX  = 8'd255;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TENTHS,
    ST_SPLIT_CM,
    ST_DUTY_PREP,
    ST_DIV_DUTY,
    ST_EMIT
  } erpi_state_t;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_RANGE,
    STEP_OVER
  } step_kind_t;

  typedef struct packed {
    logic step;
    logic cap_tenths;
    logic cap_cm;
    logic div_start;
    logic cap_duty;
    logic duty_from_div;
    logic load_out;
  } erpi_cmd_t;

  typedef struct packed {
    step_kind_t kind;
    logic       div_busy;
    logic       div_done;
    logic       needs_div;
    logic       out_free;
  } erpi_status_t;

endpackage

@@ hw/rtl/erpi_in_if.sv @@
// Input channel: one echo sample beat per timer tick.
interface erpi_in_if;
  logic valid;
  logic ready;
  logic echo;

  modport source (output valid, output echo, input ready);
  modport sink   (input valid, input echo, output ready);
endinterface

@@ hw/rtl/erpi_out_if.sv @@
// Result channel: distance, over-range flag, indicator duty and alarm.
interface erpi_out_if;
  logic                          valid;
  logic                          ready;
  logic [erpi_pkg::CM_W-1:0]     distance_cm;
  logic [erpi_pkg::DIGIT_W-1:0]  tenths_digit;
  logic                          over_range;
  logic [erpi_pkg::DUTY_W-1:0]   duty;
  logic                          alarm;

  modport source (output valid, output distance_cm, output tenths_digit, output over_range,
                  output duty, output alarm, input ready);
  modport sink   (input valid, input distance_cm, input tenths_digit, input over_range,
                  input duty, input alarm, output ready);
endinterface

@@ hw/rtl/erpi_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module erpi_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [erpi_pkg::DIV_W-1:0]   dividend,
  input  logic [erpi_pkg::DVSR_W-1:0]  divisor,
  output logic                         busy,
  output logic                         done,
  output logic [erpi_pkg::DIV_W-1:0]   quot
);
  import erpi_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  dvd_r;
  logic [DVSR_W-1:0] rem_r;
  logic [DVSR_W-1:0] dsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVSR_W:0]   sh;
  logic [DVSR_W:0]   sub;
  logic              ge;
  logic [DVSR_W-1:0] rem_nxt;

  always_comb begin
    sh      = {rem_r, dvd_r[DIV_W-1]};
    sub     = sh - {1'b0, dsr_r};
    ge      = sh >= {1'b0, dsr_r};
    rem_nxt = ge ? sub[DVSR_W-1:0] : sh[DVSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = dvd_r;

endmodule

@@ hw/rtl/erpi_dp.sv @@
// Datapath: config registers, echo timer, distance/duty arithmetic, output register.
module erpi_dp #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [erpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [erpi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_echo,
  input  erpi_pkg::erpi_cmd_t              cmd,
  output erpi_pkg::erpi_status_t           status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [erpi_pkg::CM_W-1:0]        out_distance_cm,
  output logic [erpi_pkg::DIGIT_W-1:0]     out_tenths_digit,
  output logic                             out_over_range,
  output logic [erpi_pkg::DUTY_W-1:0]      out_duty,
  output logic                             out_alarm
);
  import erpi_pkg::*;

  localparam int TW      = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
  localparam int PROD_W  = COUNT_WIDTH + 3;
  localparam int CMP_W   = (PROD_W > TDVD_W + 1) ? PROD_W : TDVD_W + 1;
  localparam int TPROD_W = 2 * TDVD_W;
  localparam int CPROD_W = 2 * TENTHS_W;

  // configuration
  logic [THR_W-1:0]     near_r;
  logic [THR_W-1:0]     far_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r    <= NEAR_RESET;
      far_r     <= FAR_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEAR:    near_r    <= cfg_wdata[THR_W-1:0];
        CFG_FAR:     far_r     <= cfg_wdata[THR_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // echo timer
  logic                   echo_prev_r;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   counting_r, counting_nxt;
  logic                   timed_out_r, timed_out_nxt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   rise, fall, hit;
  step_kind_t             kind;

  always_comb begin
    rise          = in_echo & ~echo_prev_r;
    fall          = ~in_echo & echo_prev_r;
    cnt_inc       = (&count_r) ? count_r : count_r + 1'b1;
    hit           = TW'(cnt_inc) >= TW'(timeout_r);
    kind          = STEP_NONE;
    count_nxt     = count_r;
    counting_nxt  = counting_r;
    timed_out_nxt = timed_out_r;
    priority if (rise) begin
      count_nxt     = '0;
      counting_nxt  = 1'b1;
      timed_out_nxt = 1'b0;
    end else if (fall) begin
      if (counting_r && !timed_out_r) begin
        kind = STEP_RANGE;
      end
      counting_nxt  = 1'b0;
      timed_out_nxt = 1'b0;
    end else if (counting_r) begin
      count_nxt = cnt_inc;
      if (hit) begin
        counting_nxt  = 1'b0;
        timed_out_nxt = 1'b1;
        kind          = STEP_OVER;
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_prev_r <= 1'b0;
      count_r     <= '0;
      counting_r  <= 1'b0;
      timed_out_r <= 1'b0;
    end else if (cmd.step) begin
      echo_prev_r <= in_echo;
      count_r     <= count_nxt;
      counting_r  <= counting_nxt;
      timed_out_r <= timed_out_nxt;
    end
  end

  // tenths dividend: count*5, clamped so the quotient stops at the top tenths value
  logic [PROD_W-1:0] prod;
  logic [CMP_W-1:0]  prod_ext;
  logic              tenths_sat;
  logic [TDVD_W-1:0] tenths_dvd;

  always_comb begin
    prod       = {count_r, 2'b00} + PROD_W'(count_r);
    prod_ext   = CMP_W'(prod);
    tenths_sat = prod_ext >= CMP_W'((MAX_TENTHS + 1) * TENTHS_DIVISOR);
    tenths_dvd = tenths_sat ? TDVD_W'(MAX_TENTHS * TENTHS_DIVISOR) : prod_ext[TDVD_W-1:0];
  end

  // tenths, whole cm and tenths digit by reciprocal multiplication
  logic [TPROD_W-1:0]  tenths_prod;
  logic [TENTHS_W-1:0] tenths_r;
  logic [CPROD_W-1:0]  cm_prod;
  logic [CM_W-1:0]     cm_q;
  logic [TENTHS_W-1:0] cm_x10;
  logic [TENTHS_W-1:0] digit_full;

  always_comb begin
    tenths_prod = tenths_dvd * TENTHS_RECIP;
    cm_prod     = tenths_r * CM_RECIP;
    cm_q        = cm_prod[CM_SHIFT +: CM_W];
    cm_x10      = {cm_q, 3'b000} + {2'b00, cm_q, 1'b0};
    digit_full  = tenths_r - cm_x10;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_tenths) begin
      tenths_r <= tenths_prod[TENTHS_SHIFT +: TENTHS_W];
    end
  end

  // result staging
  logic [CM_W-1:0]    res_cm_r;
  logic [DIGIT_W-1:0] res_digit_r;
  logic               res_over_r;
  logic [DUTY_W-1:0]  res_duty_r;
  logic               res_alarm_r;
  logic [DUTY_W-1:0]  duty_held_r;

  // duty classification with the near/far spacing rule
  logic signed [10:0] far_s, near_s, fm5_s, nr_s, cm_s, diff_s, span_s;
  logic               above, in_ramp_lo, ramp, alarm_c;
  logic [DUTY_W-1:0]  duty_direct;
  logic [DVSR_W-1:0]  diff9, span9;
  logic [RAMP_W-1:0]  ramp_num;

  always_comb begin
    far_s  = signed'({2'b00, far_r});
    near_s = signed'({2'b00, near_r});
    cm_s   = signed'({1'b0, res_cm_r});
    fm5_s  = far_s - 11'(SPACING_CM);
    nr_s   = near_s;
    if (fm5_s <= near_s) begin
      nr_s = (fm5_s < 11'sd1) ? 11'sd1 : fm5_s;
    end
    above       = cm_s > far_s;
    in_ramp_lo  = cm_s >= nr_s;
    ramp        = !above && in_ramp_lo && (far_s > nr_s);
    alarm_c     = !above && !in_ramp_lo;
    duty_direct = alarm_c ? '0 : DUTY_MAX;
    diff_s      = cm_s - nr_s;
    span_s      = far_s - nr_s;
    diff9       = diff_s[DVSR_W-1:0];
    span9       = span_s[DVSR_W-1:0];
    // 255*x as 256*x - x
    ramp_num    = {diff9, 8'h00} - RAMP_W'(diff9);
  end

  // duty ramp divider
  logic              div_busy, div_done;
  logic [DIV_W-1:0]  div_quot;

  erpi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (ramp_num),
    .divisor  (span9),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_held_r <= '0;
    end else if (cmd.cap_duty) begin
      duty_held_r <= cmd.duty_from_div ? div_quot[DUTY_W-1:0] : duty_direct;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && kind == STEP_OVER) begin
      res_cm_r    <= '0;
      res_digit_r <= '0;
      res_over_r  <= 1'b1;
      res_duty_r  <= duty_held_r;
      res_alarm_r <= 1'b0;
    end else if (cmd.step && kind == STEP_RANGE) begin
      res_over_r <= 1'b0;
    end
    if (cmd.cap_cm) begin
      res_cm_r    <= cm_q;
      res_digit_r <= digit_full[DIGIT_W-1:0];
    end
    if (cmd.cap_duty) begin
      res_duty_r  <= cmd.duty_from_div ? div_quot[DUTY_W-1:0] : duty_direct;
      res_alarm_r <= alarm_c;
    end
  end

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [CM_W-1:0]    out_cm_r;
  logic [DIGIT_W-1:0] out_digit_r;
  logic               out_over_r;
  logic [DUTY_W-1:0]  out_duty_r;
  logic               out_alarm_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cm_r    <= res_cm_r;
      out_digit_r <= res_digit_r;
      out_over_r  <= res_over_r;
      out_duty_r  <= res_duty_r;
      out_alarm_r <= res_alarm_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_distance_cm  = out_cm_r;
  assign out_tenths_digit = out_digit_r;
  assign out_over_range   = out_over_r;
  assign out_duty         = out_duty_r;
  assign out_alarm        = out_alarm_r;

  always_comb begin
    status.kind      = kind;
    status.div_busy  = div_busy;
    status.div_done  = div_done;
    status.needs_div = ramp;
    status.out_free  = !out_valid_r || out_ready;
  end

  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(counting_r && timed_out_r))
    else $error("timer counting after timeout");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_duty_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cap_duty && cmd.duty_from_div) |-> (div_quot <= DIV_W'(DUTY_MAX)))
    else $error("ramp quotient exceeds duty range");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_cm |=> (res_digit_r <= DIGIT_MAX))
    else $error("tenths digit out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before taken");

endmodule

@@ hw/rtl/erpi_ctrl.sv @@
// Controller: sequences the tick step, the range arithmetic, the duty division and the result beat.
module erpi_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  erpi_pkg::erpi_status_t  status,
  output erpi_pkg::erpi_cmd_t     cmd
);
  import erpi_pkg::*;

  erpi_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step = 1'b1;
          unique case (status.kind)
            STEP_RANGE: state_nxt = ST_TENTHS;
            STEP_OVER:  state_nxt = ST_EMIT;
            default: ;
          endcase
        end
      end
      ST_TENTHS: begin
        cmd.cap_tenths = 1'b1;
        state_nxt      = ST_SPLIT_CM;
      end
      ST_SPLIT_CM: begin
        cmd.cap_cm = 1'b1;
        state_nxt  = ST_DUTY_PREP;
      end
      ST_DUTY_PREP: begin
        if (status.needs_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_DUTY;
        end else begin
          cmd.cap_duty = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_DIV_DUTY: begin
        if (status.div_done) begin
          cmd.cap_duty      = 1'b1;
          cmd.duty_from_div = 1'b1;
          state_nxt         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/echo_range_proximity_indicator_unit.sv @@
// Top level: echo range timer with proximity duty and alarm.
// A tick beat with no result leaves the controller idle; the next beat is taken in the
// following cycle. An over-range result is staged, then loaded into the output register
// once it is free. A range result passes the tenths, cm split and duty prep states (and the
// 17-step radix-2 division when the duty ramp needs it) before it is loaded; no new beat is
// taken until the result is loaded. Synchronous active-low reset clears the timer, the held
// duty and the output valid flag, and loads the default thresholds and timeout.
module echo_range_proximity_indicator_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [erpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [erpi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  erpi_in_if.sink                          in_if,
  erpi_out_if.source                       out_if
);
  import erpi_pkg::*;

  erpi_cmd_t    cmd;
  erpi_status_t status;

  erpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  erpi_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_echo          (in_if.echo),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_distance_cm  (out_if.distance_cm),
    .out_tenths_digit (out_if.tenths_digit),
    .out_over_range   (out_if.over_range),
    .out_duty         (out_if.duty),
    .out_alarm        (out_if.alarm)
  );

endmodule
